// ===== src/fbsm_pkg.sv =====
package fbsm_pkg;

   // Default slot storage; the live slot count never exceeds what buffer_count can express.
   localparam int MAX_SLOTS_DEFAULT = 4;
   localparam int BUF_CNT_LIMIT     = 7;

   localparam int CMD_W      = 2;
   localparam int SLOT_IN_W  = 3;
   localparam int SLOT_OUT_W = 2;
   localparam int LEVEL_W    = 3;
   localparam int CNT_W      = 32;
   localparam int BUF_CNT_W  = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_FILL_REQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL_DONE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CAPTURE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE   = 2'd3;

   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_FILLING = 2'd1;
   localparam logic [1:0] ST_READY   = 2'd2;
   localparam logic [1:0] ST_HELD    = 2'd3;

   localparam logic [BUF_CNT_W-1:0] BUF_CNT_RESET = 3'd3;
   localparam logic [BUF_CNT_W-1:0] BUF_CNT_MIN   = 3'd2;

   // Word index of the register, taken from paddr[2].
   localparam logic CSR_IDX_BUF_CNT = 1'b0;

   typedef logic [1:0] slot_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [SLOT_IN_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot_out;
      logic                  slot_valid;
      logic                  frame_signal;
      logic                  dropped;
      logic [CNT_W-1:0]      drop_count;
      logic [LEVEL_W-1:0]    ready_count;
      logic [CNT_W-1:0]      request_count;
      logic [CNT_W-1:0]      finish_count;
   } rsp_type;

   // (ptr + 1) mod n for ptr <= 6 and 2 <= n <= 7; at most three subtractions.
   function automatic logic [2:0] wrap_inc(input logic [2:0] ptr, input logic [2:0] n);
      logic [3:0] v;
      v = {1'b0, ptr} + 4'd1;
      for (int k = 0; k < 3; k++) begin
         if (v >= {1'b0, n}) begin
            v = v - {1'b0, n};
         end
      end
      return v[2:0];
   endfunction

endpackage

// ===== src/fbsm_prio_enc.sv =====
module fbsm_prio_enc
   #(parameter int N  = 4,
     parameter int IW = 2)
   (input  logic [N-1:0]  hit,
    output logic          found,
    output logic [IW-1:0] index);

   // lowest set bit wins
   always_comb begin
      found = |hit;
      index = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (hit[i]) begin
            index = IW'(i);
         end
      end
   end

endmodule

// ===== src/frame_buffer_slot_manager.sv =====
// An accepted command is registered, then its result word is registered with rsp_valid.
// Throughput: one command per clock; busy stays low, the next command sees all state
//   updates of the one before it (state is written at the same edge as the result word).
// Reset (synchronous, active high): all slots free, ready queue empty, counters zero,
//   buffer_count back to 3; queue entries themselves are not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module frame_buffer_slot_manager
   import fbsm_pkg::*;
   #(parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT)
   (input  logic                  clock,
    input  logic                  reset,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  req_type               req_data,
    // result channel
    output logic                  rsp_valid,
    output rsp_type               rsp_data,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CSR_ADDR_W-1:0] paddr,
    input  logic [CSR_DATA_W-1:0] pwdata,
    output logic [CSR_DATA_W-1:0] prdata,
    output logic                  pready);

   // buffer_count is 3 bits, so at most 7 slots are ever live whatever MAX_SLOTS is
   localparam int USED_SLOTS = (MAX_SLOTS < BUF_CNT_LIMIT) ? MAX_SLOTS : BUF_CNT_LIMIT;
   localparam int IW         = $clog2(USED_SLOTS);

   // ---------------------------------------------------------------- registers
   logic                  req_valid_ff, req_valid_in;
   req_type               req_ff;

   logic                  rsp_valid_ff;
   logic [SLOT_OUT_W-1:0] slot_out_ff, slot_out_in;
   logic                  slot_valid_ff, slot_valid_in;
   logic                  frame_ff, frame_in;
   logic                  dropped_ff, dropped_in;

   logic [BUF_CNT_W-1:0]  buf_cnt_ff, buf_cnt_in;
   slot_state_type        state_ff [USED_SLOTS];
   slot_state_type        state_in [USED_SLOTS];
   logic [IW-1:0]         fifo_ff  [USED_SLOTS];
   logic [IW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [CNT_W-1:0]      drops_ff, drops_in;
   logic [CNT_W-1:0]      requests_ff, requests_in;
   logic [CNT_W-1:0]      finishes_ff, finishes_in;

   // ---------------------------------------------------------------- register port
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_BUF_CNT);
   assign buf_cnt_in = csr_wr ? pwdata[BUF_CNT_W-1:0] : buf_cnt_ff;

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_BUF_CNT) begin
         prdata = CSR_DATA_W'(buf_cnt_ff);
      end
   end

   // ---------------------------------------------------------------- command intake
   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   // ---------------------------------------------------------------- slot count in use
   logic [2:0] n_slots;

   always_comb begin
      priority if (buf_cnt_ff < BUF_CNT_MIN) begin
         n_slots = BUF_CNT_MIN;
      end else if (buf_cnt_ff > 3'(USED_SLOTS)) begin
         n_slots = 3'(USED_SLOTS);
      end else begin
         n_slots = buf_cnt_ff;
      end
   end

   // ---------------------------------------------------------------- slot scans
   logic [USED_SLOTS-1:0] free_hit, fill_hit;
   logic                  free_found, fill_found;
   logic [IW-1:0]         free_idx, fill_idx;

   always_comb begin
      for (int i = 0; i < USED_SLOTS; i++) begin
         free_hit[i] = (3'(i) < n_slots) && (state_ff[i] == ST_FREE);
         fill_hit[i] = (3'(i) < n_slots) && (state_ff[i] == ST_FILLING);
      end
   end

   fbsm_prio_enc #(.N(USED_SLOTS), .IW(IW)) u_free_enc
      (.hit(free_hit), .found(free_found), .index(free_idx));

   fbsm_prio_enc #(.N(USED_SLOTS), .IW(IW)) u_fill_enc
      (.hit(fill_hit), .found(fill_found), .index(fill_idx));

   // ---------------------------------------------------------------- ready queue view
   logic [IW-1:0] head;
   logic          head_ok;      // head entry names a slot still in use
   logic          q_nonempty;
   logic [IW-1:0] rd_ptr_adv, wr_ptr_adv;
   logic          slot_ok;
   logic [IW-1:0] slot_idx;

   assign head       = fifo_ff[rd_ptr_ff];
   assign head_ok    = 3'(head) < n_slots;
   assign q_nonempty = level_ff != '0;
   assign rd_ptr_adv = IW'(wrap_inc(3'(rd_ptr_ff), n_slots));
   assign wr_ptr_adv = IW'(wrap_inc(3'(wr_ptr_ff), n_slots));
   assign slot_ok    = req_ff.slot < n_slots;
   assign slot_idx   = IW'(req_ff.slot);   // only used when slot_ok

   // ---------------------------------------------------------------- command logic
   logic               pop, push;
   logic [LEVEL_W-1:0] level_popped;

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      push          = 1'b0;
      slot_out_in   = '0;
      slot_valid_in = 1'b0;
      frame_in      = 1'b0;
      dropped_in    = 1'b0;
      requests_in   = requests_ff;
      finishes_in   = finishes_ff;
      level_popped  = level_ff;

      if (req_valid_ff) begin
         unique case (req_ff.command)
            CMD_FILL_REQ: begin
               requests_in   = requests_ff + 32'd1;
               slot_valid_in = 1'b1;
               if (free_found) begin
                  state_in[free_idx] = ST_FILLING;
                  slot_out_in        = SLOT_OUT_W'(free_idx);
               end else begin
                  // overwrite path: oldest ready, then a slot mid-fill, then slot 0
                  pop        = q_nonempty;
                  dropped_in = 1'b1;
                  priority if (q_nonempty && head_ok) begin
                     state_in[head] = ST_FILLING;
                     slot_out_in    = SLOT_OUT_W'(head);
                  end else if (fill_found) begin
                     slot_out_in = SLOT_OUT_W'(fill_idx);
                  end else begin
                     slot_out_in = '0;
                  end
               end
            end
            CMD_FILL_DONE: begin
               finishes_in = finishes_ff + 32'd1;
               frame_in    = 1'b1;
               if (slot_ok) begin
                  // backlog full: retire the oldest ready frame first
                  if (({1'b0, level_ff} + 4'd1 >= {1'b0, n_slots}) && q_nonempty) begin
                     pop          = 1'b1;
                     level_popped = level_ff - 3'd1;
                     if (head_ok) begin
                        state_in[head] = ST_FREE;
                        dropped_in     = 1'b1;
                     end
                  end
                  state_in[slot_idx] = ST_READY;
                  push               = level_popped < n_slots;
               end
            end
            CMD_CAPTURE: begin
               pop = q_nonempty;
               if (q_nonempty && head_ok) begin
                  state_in[head] = ST_HELD;
                  slot_out_in    = SLOT_OUT_W'(head);
                  slot_valid_in  = 1'b1;
               end
            end
            CMD_RELEASE: begin
               if (slot_ok && state_ff[slot_idx] == ST_HELD) begin
                  state_in[slot_idx] = ST_FREE;
               end
            end
            default: begin
            end
         endcase
      end

      rd_ptr_in = pop  ? rd_ptr_adv : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_adv : wr_ptr_ff;
      level_in  = level_ff - LEVEL_W'(pop) + LEVEL_W'(push);
      drops_in  = drops_ff + CNT_W'(dropped_in);
   end

   // ---------------------------------------------------------------- state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         buf_cnt_ff   <= BUF_CNT_RESET;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         level_ff     <= '0;
         drops_ff     <= '0;
         requests_ff  <= '0;
         finishes_ff  <= '0;
         for (int i = 0; i < USED_SLOTS; i++) begin
            state_ff[i] <= ST_FREE;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
         buf_cnt_ff   <= buf_cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         level_ff     <= level_in;
         drops_ff     <= drops_in;
         requests_ff  <= requests_in;
         finishes_ff  <= finishes_in;
         state_ff     <= state_in;
      end
   end

   // payload: command word, result word, queue entries
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      slot_out_ff   <= slot_out_in;
      slot_valid_ff <= slot_valid_in;
      frame_ff      <= frame_in;
      dropped_ff    <= dropped_in;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= slot_idx;
      end
   end

   // ---------------------------------------------------------------- result word
   // counters and level are read straight from state, which moves with the result
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.slot_out      = slot_out_ff;
   assign rsp_data.slot_valid    = slot_valid_ff;
   assign rsp_data.frame_signal  = frame_ff;
   assign rsp_data.dropped       = dropped_ff;
   assign rsp_data.drop_count    = drops_ff;
   assign rsp_data.ready_count   = level_ff;
   assign rsp_data.request_count = requests_ff;
   assign rsp_data.finish_count  = finishes_ff;

endmodule

// ===== src/fbsm_checker.sv =====
module fbsm_checker
   import fbsm_pkg::*;
   (input logic    clock,
    input logic    reset,
    input logic    start,
    input logic    busy,
    input logic    rsp_valid,
    input rsp_type rsp_data);

   // no result word right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   // every accepted command yields a result word
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted command produced no result word");

   // no result word without an earlier accepted command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result word without a command");

   // fill done never hands out a slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_signal) |-> !rsp_data.slot_valid)
      else $error("fill done reported a slot");

   // drop count moves only with a reported drop
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.dropped && $past(rsp_valid))
         |-> rsp_data.drop_count == $past(rsp_data.drop_count))
      else $error("drop count changed without a drop");

endmodule

bind frame_buffer_slot_manager fbsm_checker u_fbsm_checker
   (.clock(clock),
    .reset(reset),
    .start(start),
    .busy(busy),
    .rsp_valid(rsp_valid),
    .rsp_data(rsp_data));
